### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that stays armed through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/i2cscp_pkg.sv
// Shared types and codes of the counter command port.
// No dependencies; used by all modules of the block.
package i2cscp_pkg;

    // Bus and sensor event codes
    localparam logic [2:0] OP_ADDR_WRITE = 3'd0;
    localparam logic [2:0] OP_ADDR_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
    localparam logic [2:0] OP_READ_NEXT  = 3'd3;
    localparam logic [2:0] OP_PULSE      = 3'd4;
    localparam logic [2:0] OP_VOLTAGE    = 3'd5;

    // Command bytes
    localparam logic [7:0] CMD_BEGIN    = 8'h01;
    localparam logic [7:0] CMD_HALT     = 8'h02;
    localparam logic [7:0] CMD_CLEAR    = 8'h03;
    localparam logic [7:0] CMD_SET_DAC  = 8'h04;
    localparam logic [7:0] CMD_GET_VOLT = 8'h05;

    // Reply lengths in bytes and argument count of set-voltage
    localparam logic [2:0] VOLT_REPLY_LEN  = 3'd2;
    localparam logic [2:0] COUNT_REPLY_LEN = 3'd4;
    localparam logic [1:0] SET_DAC_ARGS    = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  data_byte;
        logic [11:0] voltage_sample;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        dac_write;
        logic [11:0] dac_value;
        logic        counting_on;
    } result_t;

endpackage

### hw/rtl/i2c_slave_counter_command_port_core.sv
// Command port of a bus-slave pulse counter. Each input transaction is one event: address
// write, address read, write byte, read next, pulse, or voltage sample; each produces exactly
// one result transaction. Throughput is one transaction per clock while m_ready is high;
// a stalled result holds the pipeline. The event is held in an input register, decoded
// against the command state combinationally, and the result is loaded into an output
// register until the consumer takes it. The command and count state (including the 32-bit
// pulse counter) is registered together with the result. The first byte written
// after an address phase is the command: 0x01 start counting (LED on), 0x02 stop and request
// DAC code 0, 0x03 clear the count, 0x04 set-voltage (two more bytes, high first, low
// 12 bits sent to the DAC). Reads return the voltage as two bytes after command 0x05,
// otherwise the count as four bytes, MSB first.
module i2c_slave_counter_command_port_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Event channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [7:0]  s_data_byte,
    input  logic [11:0] s_voltage_sample,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_dac_write,
    output logic [11:0] m_dac_value,
    output logic        m_counting_on
);

    i2cscp_pkg::item_t   s_item;
    i2cscp_pkg::item_t   item;
    i2cscp_pkg::result_t result;
    i2cscp_pkg::result_t m_result;
    logic                item_valid;
    logic                fire;
    logic                out_ready;

    assign s_item.operation      = s_operation;
    assign s_item.data_byte      = s_data_byte;
    assign s_item.voltage_sample = s_voltage_sample;

    // Hold the incoming transaction; advance it when the result register has room
    i2cscp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .down_ready (out_ready),
        .item_valid (item_valid),
        .item       (item),
        .fire       (fire)
    );

    // Decode the event, update command/count state, form the result
    i2cscp_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire && item_valid),
        .item    (item),
        .result  (result)
    );

    // Hold the result until the consumer takes it
    i2cscp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .up_ready (out_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_tx_valid    = m_result.tx_valid;
    assign m_tx_byte     = m_result.tx_byte;
    assign m_dac_write   = m_result.dac_write;
    assign m_dac_value   = m_result.dac_value;
    assign m_counting_on = m_result.counting_on;

endmodule

### hw/rtl/i2cscp_in_stage.sv
// Input register of the counter command port.
// Depends on i2cscp_pkg (item_t).
module i2cscp_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  i2cscp_pkg::item_t  s_item,
    input  logic               down_ready,
    output logic               item_valid,
    output i2cscp_pkg::item_t  item,
    output logic               fire
);

    logic              valid_reg;
    logic              valid_next;
    i2cscp_pkg::item_t item_reg;

    assign fire    = valid_reg && down_ready;
    assign s_ready = !valid_reg || down_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (fire) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load on accept only
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/i2cscp_engine.sv
// Command state and event decode of the counter command port.
// Depends on i2cscp_pkg (codes, item_t, result_t).
module i2cscp_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  i2cscp_pkg::item_t    item,
    output i2cscp_pkg::result_t  result
);

    logic [7:0]  cmd_reg,         cmd_next;
    logic [1:0]  wr_pos_reg,      wr_pos_next;
    logic [2:0]  rd_pos_reg,      rd_pos_next;
    logic [31:0] pulse_total_reg, pulse_total_next;
    logic        count_en_reg,    count_en_next;
    logic [11:0] volt_reg,        volt_next;
    logic [7:0]  arg_reg  [2];
    logic [7:0]  arg_next [2];

    logic [7:0]  cmd_cur;
    logic [1:0]  wr_pos_m1;
    logic [1:0]  args_needed;
    logic [2:0]  reply_len;
    logic [7:0]  reply_rd;
    logic [7:0]  reply_first;

    // Byte pos of the read reply, most significant first
    function automatic logic [7:0] reply_byte(
        input logic [7:0]  cmd,
        input logic [1:0]  pos,
        input logic [31:0] total,
        input logic [11:0] volt
    );
        logic [7:0] b;
        b = 8'h00;
        if (cmd == i2cscp_pkg::CMD_GET_VOLT) begin
            b = (pos == 2'd0) ? {4'h0, volt[11:8]} : volt[7:0];
        end else begin
            case (pos)
                2'd0:    b = total[31:24];
                2'd1:    b = total[23:16];
                2'd2:    b = total[15:8];
                default: b = total[7:0];
            endcase
        end
        return b;
    endfunction

    assign reply_len   = (cmd_reg == i2cscp_pkg::CMD_GET_VOLT) ?
                         i2cscp_pkg::VOLT_REPLY_LEN : i2cscp_pkg::COUNT_REPLY_LEN;
    assign reply_rd    = reply_byte(cmd_reg, rd_pos_reg[1:0], pulse_total_reg, volt_reg);
    assign reply_first = reply_byte(cmd_reg, 2'd0, pulse_total_reg, volt_reg);
    assign cmd_cur     = (wr_pos_reg == 2'd0) ? item.data_byte : cmd_reg;
    assign wr_pos_m1   = wr_pos_reg - 2'd1;
    assign args_needed = (cmd_cur == i2cscp_pkg::CMD_SET_DAC) ?
                         i2cscp_pkg::SET_DAC_ARGS : 2'd0;

    always_comb begin
        cmd_next         = cmd_reg;
        wr_pos_next      = wr_pos_reg;
        rd_pos_next      = rd_pos_reg;
        pulse_total_next = pulse_total_reg;
        count_en_next    = count_en_reg;
        volt_next        = volt_reg;
        arg_next         = arg_reg;
        result           = '0;
        if (fire) begin
            unique case (item.operation)
                i2cscp_pkg::OP_ADDR_WRITE: begin
                    wr_pos_next = 2'd0;
                    rd_pos_next = 3'd0;
                end
                i2cscp_pkg::OP_ADDR_READ: begin
                    wr_pos_next     = 2'd0;
                    rd_pos_next     = 3'd1;
                    result.tx_valid = 1'b1;
                    result.tx_byte  = reply_first;
                end
                i2cscp_pkg::OP_WRITE_BYTE: begin
                    cmd_next = cmd_cur;
                    if (wr_pos_reg != 2'd0) begin
                        arg_next[wr_pos_m1[0]] = item.data_byte;
                    end
                    if (wr_pos_reg >= args_needed) begin
                        wr_pos_next = 2'd0;
                        unique case (cmd_cur)
                            i2cscp_pkg::CMD_BEGIN: begin
                                count_en_next = 1'b1;
                            end
                            i2cscp_pkg::CMD_HALT: begin
                                count_en_next    = 1'b0;
                                result.dac_write = 1'b1;
                            end
                            i2cscp_pkg::CMD_CLEAR: begin
                                pulse_total_next = 32'd0;
                            end
                            i2cscp_pkg::CMD_SET_DAC: begin
                                result.dac_write = 1'b1;
                                result.dac_value = {arg_next[0][3:0], arg_next[1]};
                            end
                            default: ;
                        endcase
                    end else begin
                        wr_pos_next = wr_pos_reg + 2'd1;
                    end
                end
                i2cscp_pkg::OP_READ_NEXT: begin
                    if (rd_pos_reg < reply_len) begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = reply_rd;
                        rd_pos_next     = rd_pos_reg + 3'd1;
                    end
                end
                i2cscp_pkg::OP_PULSE: begin
                    if (count_en_reg) begin
                        pulse_total_next = pulse_total_reg + 32'd1;
                    end
                end
                i2cscp_pkg::OP_VOLTAGE: begin
                    volt_next = item.voltage_sample;
                end
                default: ;
            endcase
        end
        result.counting_on = count_en_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg         <= 8'h00;
            wr_pos_reg      <= 2'd0;
            rd_pos_reg      <= 3'd0;
            pulse_total_reg <= 32'd0;
            count_en_reg    <= 1'b0;
            volt_reg        <= 12'd0;
        end else begin
            cmd_reg         <= cmd_next;
            wr_pos_reg      <= wr_pos_next;
            rd_pos_reg      <= rd_pos_next;
            pulse_total_reg <= pulse_total_next;
            count_en_reg    <= count_en_next;
            volt_reg        <= volt_next;
        end
    end

    // Argument bytes are read only after being written
    always_ff @(posedge aclk) begin
        arg_reg <= arg_next;
    end

endmodule

### hw/rtl/i2cscp_out_stage.sv
// Result register of the counter command port.
// Depends on i2cscp_pkg (result_t).
module i2cscp_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  i2cscp_pkg::result_t  result,
    output logic                 up_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cscp_pkg::result_t  m_result
);

    logic                valid_reg;
    logic                valid_next;
    i2cscp_pkg::result_t result_reg;

    assign up_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

### hw/rtl/i2cscp_checker.sv
// Port-level checks of the counter command port, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module i2cscp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_tx_valid,
    input logic [7:0]  m_tx_byte,
    input logic        m_dac_write,
    input logic [11:0] m_dac_value
);

    `ASSERT_CLK_RST(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_dac_value), "result changed while stalled")
    `ASSERT_CLK_RST(a_tx_idle_zero, aclk, aresetn, m_valid && !m_tx_valid |-> m_tx_byte == 8'h00, "tx byte not zero without tx valid")
    `ASSERT_CLK_RST(a_dac_idle_zero, aclk, aresetn, m_valid && !m_dac_write |-> m_dac_value == 12'h000, "dac value not zero without dac write")
    `ASSERT_CLK_RST(a_tx_dac_excl, aclk, aresetn, m_valid && m_tx_valid |-> !m_dac_write, "read byte and dac write in one result")
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind i2c_slave_counter_command_port_core i2cscp_checker u_i2cscp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_tx_valid  (m_tx_valid),
    .m_tx_byte   (m_tx_byte),
    .m_dac_write (m_dac_write),
    .m_dac_value (m_dac_value)
);
